// ===== src/hsb_to_rgb_dim_curve_defines.svh =====
// Assertion macros used by the checker file of the color converter.
// No dependencies; included by bare file name.
`ifndef HSB_TO_RGB_DIM_CURVE_DEFINES_SVH
`define HSB_TO_RGB_DIM_CURVE_DEFINES_SVH

// Same-cycle implication, disabled while dis is high
`define HSBRGB_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while dis is high
`define HSBRGB_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/hsbrgb_pkg.sv =====
// Shared constants, dim curve table and stage payload types for the
// hue/saturation/brightness to RGB converter. No dependencies.
package hsbrgb_pkg;

   localparam logic [7:0] FULL_LEVEL = 8'd255;
   localparam logic [8:0] HUE_TURN   = 9'd360;
   localparam int         SECTOR_DEG = 60;

   // floor(x / 60) == (x * RECIP60) >> DIV_SHIFT, exact for x below 2^14
   localparam logic [14:0] RECIP60   = 15'd17477;
   localparam int          DIV_SHIFT = 20;

   // Perceptual dim curve
   localparam logic [7:0] DIM_CURVE [256] = '{
      8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
      8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
      8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
      8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
      8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
      8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
      8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
      8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
      8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
      8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
      8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
      8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
      8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
      8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
      8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
      8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
      8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
      8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
      8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
      8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
      8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
      8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
      8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
      8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
      8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
      8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
      8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
      8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
      8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
   };

   // 60-degree hue sectors, named by the colors they run between
   typedef enum logic [2:0] {
      SEC_R_TO_Y = 3'd0,
      SEC_Y_TO_G = 3'd1,
      SEC_G_TO_C = 3'd2,
      SEC_C_TO_B = 3'd3,
      SEC_B_TO_M = 3'd4,
      SEC_M_TO_R = 3'd5
   } sector_type;

   // Front end result: peak, floor, grey flag, sector and offset
   typedef struct packed {
      logic [7:0] peak;
      logic [7:0] base;
      logic       grey;
      sector_type sector;
      logic [5:0] offset;
   } front_type;

   // Ramp result: quotient of the ramp term
   typedef struct packed {
      logic [7:0] peak;
      logic [7:0] base;
      logic       grey;
      sector_type sector;
      logic [7:0] quot;
   } ramp_type;

endpackage

// ===== src/hsbrgb_front.sv =====
// Front two pipeline stages: hue wrap and dim curve lookups, then floor
// level multiply and sector split. Depends on hsbrgb_pkg.
module hsbrgb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [8:0]            in_hue,
   input  logic [7:0]            in_sat,
   input  logic [7:0]            in_bri,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsbrgb_pkg::front_type out_data
);

   // stage A registers
   logic       a_valid_ff;
   logic [8:0] a_hue_ff,  a_hue_in;
   logic [7:0] a_peak_ff, a_peak_in;
   logic [7:0] a_wash_ff, a_wash_in;
   logic       a_ready;

   // stage B registers
   logic                  b_valid_ff;
   hsbrgb_pkg::front_type b_data_ff, b_data_in;
   logic                  b_ready;
   logic [15:0]           floor_prod;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Stage A: wrap hue, look up peak level and inverted saturation
   always_comb begin
      a_hue_in  = (in_hue >= hsbrgb_pkg::HUE_TURN) ? in_hue - hsbrgb_pkg::HUE_TURN : in_hue;
      a_peak_in = hsbrgb_pkg::DIM_CURVE[in_bri];
      a_wash_in = hsbrgb_pkg::DIM_CURVE[~in_sat];
   end

   // Stage B: floor = (255 - s) * v >> 8, where 255 - s is the curve value
   always_comb begin
      floor_prod       = 16'(a_wash_ff) * 16'(a_peak_ff);
      b_data_in.peak   = a_peak_ff;
      b_data_in.base   = floor_prod[15:8];
      b_data_in.grey   = (a_wash_ff == hsbrgb_pkg::FULL_LEVEL);
      if (a_hue_ff >= 9'(5 * hsbrgb_pkg::SECTOR_DEG)) begin
         b_data_in.sector = hsbrgb_pkg::SEC_M_TO_R;
         b_data_in.offset = 6'(a_hue_ff - 9'(5 * hsbrgb_pkg::SECTOR_DEG));
      end else if (a_hue_ff >= 9'(4 * hsbrgb_pkg::SECTOR_DEG)) begin
         b_data_in.sector = hsbrgb_pkg::SEC_B_TO_M;
         b_data_in.offset = 6'(a_hue_ff - 9'(4 * hsbrgb_pkg::SECTOR_DEG));
      end else if (a_hue_ff >= 9'(3 * hsbrgb_pkg::SECTOR_DEG)) begin
         b_data_in.sector = hsbrgb_pkg::SEC_C_TO_B;
         b_data_in.offset = 6'(a_hue_ff - 9'(3 * hsbrgb_pkg::SECTOR_DEG));
      end else if (a_hue_ff >= 9'(2 * hsbrgb_pkg::SECTOR_DEG)) begin
         b_data_in.sector = hsbrgb_pkg::SEC_G_TO_C;
         b_data_in.offset = 6'(a_hue_ff - 9'(2 * hsbrgb_pkg::SECTOR_DEG));
      end else if (a_hue_ff >= 9'(hsbrgb_pkg::SECTOR_DEG)) begin
         b_data_in.sector = hsbrgb_pkg::SEC_Y_TO_G;
         b_data_in.offset = 6'(a_hue_ff - 9'(hsbrgb_pkg::SECTOR_DEG));
      end else begin
         b_data_in.sector = hsbrgb_pkg::SEC_R_TO_Y;
         b_data_in.offset = a_hue_ff[5:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_hue_ff  <= a_hue_in;
         a_peak_ff <= a_peak_in;
         a_wash_ff <= a_wash_in;
      end
      if (b_ready && a_valid_ff) b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ===== src/hsbrgb_ramp.sv =====
// Two ramp stages: (peak - floor) * t, then divide by 60 through a
// reciprocal multiply. Depends on hsbrgb_pkg.
module hsbrgb_ramp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsbrgb_pkg::front_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsbrgb_pkg::ramp_type  out_data
);

   // stage C registers
   logic                   c_valid_ff;
   logic [7:0]             c_peak_ff, c_base_ff;
   logic                   c_grey_ff;
   hsbrgb_pkg::sector_type c_sector_ff;
   logic [13:0]            c_prod_ff, c_prod_in;
   logic                   c_ready;
   logic                   rising;
   logic [5:0]             ramp_t;
   logic [7:0]             span;

   // stage D registers
   logic                 d_valid_ff;
   hsbrgb_pkg::ramp_type d_data_ff, d_data_in;
   logic                 d_ready;
   logic [28:0]          quot_full;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   // Stage C: ramp offset rises or falls with the sector
   always_comb begin
      rising    = (in_data.sector == hsbrgb_pkg::SEC_R_TO_Y) ||
                  (in_data.sector == hsbrgb_pkg::SEC_G_TO_C) ||
                  (in_data.sector == hsbrgb_pkg::SEC_B_TO_M);
      ramp_t    = rising ? in_data.offset : 6'(hsbrgb_pkg::SECTOR_DEG) - in_data.offset;
      span      = in_data.peak - in_data.base;
      c_prod_in = 14'(span) * 14'(ramp_t);
   end

   // Stage D: floor(prod / 60)
   always_comb begin
      quot_full        = 29'(c_prod_ff) * 29'(hsbrgb_pkg::RECIP60);
      d_data_in.peak   = c_peak_ff;
      d_data_in.base   = c_base_ff;
      d_data_in.grey   = c_grey_ff;
      d_data_in.sector = c_sector_ff;
      d_data_in.quot   = quot_full[hsbrgb_pkg::DIV_SHIFT +: 8];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (c_ready) c_valid_ff <= in_valid;
         if (d_ready) d_valid_ff <= c_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (c_ready && in_valid) begin
         c_peak_ff   <= in_data.peak;
         c_base_ff   <= in_data.base;
         c_grey_ff   <= in_data.grey;
         c_sector_ff <= in_data.sector;
         c_prod_ff   <= c_prod_in;
      end
      if (d_ready && c_valid_ff) d_data_ff <= d_data_in;
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

// ===== src/hsbrgb_mix.sv =====
// Output stage: adds the floor to the ramp quotient and routes peak,
// floor and ramp to the channels (peak to all when grey). Depends on hsbrgb_pkg.
module hsbrgb_mix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsbrgb_pkg::ramp_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           red,
   output logic [7:0]           green,
   output logic [7:0]           blue
);

   logic       e_valid_ff;
   logic [7:0] e_red_ff,   e_red_in;
   logic [7:0] e_green_ff, e_green_in;
   logic [7:0] e_blue_ff,  e_blue_in;
   logic [7:0] ramp;
   logic [7:0] pk;
   logic [7:0] fl;

   assign in_ready = !e_valid_ff || out_ready;

   // channel routing per sector
   always_comb begin
      pk   = in_data.peak;
      fl   = in_data.base;
      ramp = in_data.quot + fl;
      case (in_data.sector)
         hsbrgb_pkg::SEC_R_TO_Y: begin
            e_red_in = pk;   e_green_in = ramp; e_blue_in = fl;
         end
         hsbrgb_pkg::SEC_Y_TO_G: begin
            e_red_in = ramp; e_green_in = pk;   e_blue_in = fl;
         end
         hsbrgb_pkg::SEC_G_TO_C: begin
            e_red_in = fl;   e_green_in = pk;   e_blue_in = ramp;
         end
         hsbrgb_pkg::SEC_C_TO_B: begin
            e_red_in = fl;   e_green_in = ramp; e_blue_in = pk;
         end
         hsbrgb_pkg::SEC_B_TO_M: begin
            e_red_in = ramp; e_green_in = fl;   e_blue_in = pk;
         end
         default: begin
            e_red_in = pk;   e_green_in = fl;   e_blue_in = ramp;
         end
      endcase
      // zero saturation: grey at peak level
      if (in_data.grey) begin
         e_red_in   = pk;
         e_green_in = pk;
         e_blue_in  = pk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (in_ready) begin
         e_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         e_red_ff   <= e_red_in;
         e_green_ff <= e_green_in;
         e_blue_ff  <= e_blue_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign red       = e_red_ff;
   assign green     = e_green_ff;
   assign blue      = e_blue_ff;

endmodule

// ===== src/hsb_to_rgb_dim_curve.sv =====
// Top level of the hue/saturation/brightness to RGB level converter.
// Depends on hsbrgb_pkg, hsbrgb_front, hsbrgb_ramp and hsbrgb_mix.
//
// Usage:
//   req_* carries one color per transaction: hue in degrees (wrapped modulo
//   360), saturation and brightness. rsp_* returns one transaction per
//   request with the red, green and blue PWM levels, in request order.
//   Five register stages: curve lookup, floor multiply, ramp multiply,
//   divide-by-60 reciprocal multiply and output routing. Throughput is one
//   transaction per cycle; the three multipliers are in separate stages
//   so a new color enters every clock unless a low rsp_tready has filled
//   the pipeline and holds it.
//   Every stage has its own valid bit and takes new data when it is empty
//   or its successor moves, so a stalled rsp_tready fills bubbles first and
//   then holds the pipeline without dropping or repeating anything.
//   rsp_tdata is held stable while rsp_tvalid is high and rsp_tready low.
//   Synchronous reset empties all stages; req_tready is high right after.
module hsb_to_rgb_dim_curve (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // hue[8:0], saturation[16:9], brightness[24:17], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // red_level[7:0], green_level[15:8], blue_level[23:16]
);

   logic                  front_valid, front_ready;
   hsbrgb_pkg::front_type front_data;
   logic                  ramp_valid, ramp_ready;
   hsbrgb_pkg::ramp_type  ramp_data;
   logic [7:0]            red_level, green_level, blue_level;

   hsbrgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_hue    (req_tdata[8:0]),
      .in_sat    (req_tdata[16:9]),
      .in_bri    (req_tdata[24:17]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   hsbrgb_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (ramp_valid),
      .out_ready (ramp_ready),
      .out_data  (ramp_data)
   );

   hsbrgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ramp_valid),
      .in_ready  (ramp_ready),
      .in_data   (ramp_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .red       (red_level),
      .green     (green_level),
      .blue      (blue_level)
   );

   assign rsp_tdata = {blue_level, green_level, red_level};

endmodule

// ===== src/hsbrgb_checker.sv =====
// Port-level checker for the color converter, bound to the top level.
// Depends on hsb_to_rgb_dim_curve_defines.svh.
`include "hsb_to_rgb_dim_curve_defines.svh"

module hsbrgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   localparam logic [2:0] PIPE_DEPTH = 3'd5;

   // transactions inside the pipeline
   logic [2:0] occ_ff, occ_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      occ_in = occ_ff;
      if (req_fire && !rsp_fire) occ_in = occ_ff + 3'd1;
      if (!req_fire && rsp_fire) occ_in = occ_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 3'd0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `HSBRGB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")
   `HSBRGB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready, "pipeline not empty after reset")
   `HSBRGB_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_tvalid, req_tready, "req_tready low with empty output")
   `HSBRGB_ASSERT_NOW(a_no_phantom, clock, reset, rsp_tvalid, occ_ff != 3'd0, "response without request")
   `HSBRGB_ASSERT_NOW(a_depth, clock, reset, 1'b1, occ_ff <= PIPE_DEPTH, "more transactions than stages")

endmodule

bind hsb_to_rgb_dim_curve hsbrgb_checker u_hsbrgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
